// ===== rtl/tcsm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the tcp connection state machine
package tcsm_pkg;

	localparam logic [9:0]  MAX_SEGMENT   = 10'd536;
	localparam logic [31:0] EST_SEQ       = 32'd2;
	localparam logic [31:0] EST_WINDOW    = 32'd3072;
	localparam logic        RST_ACTIVE    = 1'b1;
	localparam logic [15:0] RST_ADV_WIN   = 16'd3072;
	localparam logic [31:0] RST_INIT_SEQ  = 32'd1;

	localparam logic [7:0] F_FIN = 8'h01;
	localparam logic [7:0] F_SYN = 8'h02;
	localparam logic [7:0] F_ACK = 8'h10;

	// register indexes of the configuration port
	localparam logic [1:0] REG_ACTIVE_OPEN = 2'd0;
	localparam logic [1:0] REG_ADV_WINDOW  = 2'd1;
	localparam logic [1:0] REG_INITIAL_SEQ = 2'd2;

	// external state codes
	localparam logic [3:0] CS_EST        = 4'd0;
	localparam logic [3:0] CS_SYN_SENT   = 4'd1;
	localparam logic [3:0] CS_LISTEN     = 4'd2;
	localparam logic [3:0] CS_SYN_RCVD   = 4'd3;
	localparam logic [3:0] CS_FW1        = 4'd4;
	localparam logic [3:0] CS_FW2        = 4'd5;
	localparam logic [3:0] CS_CLOSED     = 4'd6;
	localparam logic [3:0] CS_CLOSE_WAIT = 4'd7;
	localparam logic [3:0] CS_LAST_ACK   = 4'd8;
	localparam logic [3:0] CS_CLOSING    = 4'd9;

	typedef enum logic [1:0] {
		REQ_OPEN  = 2'd0,
		REQ_SEG   = 2'd1,
		REQ_APP   = 2'd2,
		REQ_CLOSE = 2'd3
	} req_e_t;

	typedef enum logic [9:0] {
		LS_EST        = 10'b0000000001,
		LS_SYN_SENT   = 10'b0000000010,
		LS_LISTEN     = 10'b0000000100,
		LS_SYN_RCVD   = 10'b0000001000,
		LS_FW1        = 10'b0000010000,
		LS_FW2        = 10'b0000100000,
		LS_CLOSED     = 10'b0001000000,
		LS_CLOSE_WAIT = 10'b0010000000,
		LS_LAST_ACK   = 10'b0100000000,
		LS_CLOSING    = 10'b1000000000
	} link_e_t;

	typedef struct packed {
		logic        active_open;
		logic [15:0] adv_window;
		logic [31:0] initial_seq;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [7:0]  seg_flags;
		logic [9:0]  seg_payload_len;
		logic        seg_truncated;
		logic [9:0]  app_len;
	} item_t;

	typedef struct packed {
		link_e_t     link;
		logic [31:0] next_send_seq;
		logic [31:0] ack_to_send;
		logic [31:0] peer_last_ack;
		logic [31:0] send_window;
		logic        finished;
	} conn_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_flags;
		logic [31:0] send_seq;
		logic [31:0] send_ack;
		logic [15:0] send_win;
		logic [9:0]  send_payload_len;
		logic [9:0]  deliver_len;
		logic        fin_to_app;
		logic [3:0]  conn_state;
		logic        done_res;
		logic        error;
	} res_t;

	function automatic logic [3:0] encode_state(input link_e_t ls);
		logic [3:0] code;
		unique case (ls)
			LS_EST:        code = CS_EST;
			LS_SYN_SENT:   code = CS_SYN_SENT;
			LS_LISTEN:     code = CS_LISTEN;
			LS_SYN_RCVD:   code = CS_SYN_RCVD;
			LS_FW1:        code = CS_FW1;
			LS_FW2:        code = CS_FW2;
			LS_CLOSED:     code = CS_CLOSED;
			LS_CLOSE_WAIT: code = CS_CLOSE_WAIT;
			LS_LAST_ACK:   code = CS_LAST_ACK;
			LS_CLOSING:    code = CS_CLOSING;
			default:       code = CS_CLOSED;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/tcsm_step.sv =====
`timescale 1ns / 1ps
// next connection state and emitted header for one event
module tcsm_step (
	input  tcsm_pkg::cfg_t  cfg,
	input  tcsm_pkg::item_t item,
	input  tcsm_pkg::conn_t cur,
	output tcsm_pkg::conn_t nxt,
	output tcsm_pkg::res_t  res
);

	logic [9:0]  plen;
	logic [9:0]  lim;
	logic [9:0]  sz;
	logic        connected;
	logic        snd;
	logic [7:0]  fl;
	logic [31:0] sq;
	logic [31:0] ak;
	logic [9:0]  pay;
	logic [9:0]  deliver;
	logic        fin_app;
	logic        err;
	logic [31:0] seq_plus_one;
	logic [31:0] seq_plus_len;

	always_comb begin
		plen = (item.seg_payload_len > tcsm_pkg::MAX_SEGMENT) ?
			tcsm_pkg::MAX_SEGMENT : item.seg_payload_len;
		lim = (cur.send_window < {22'd0, tcsm_pkg::MAX_SEGMENT}) ?
			cur.send_window[9:0] : tcsm_pkg::MAX_SEGMENT;
		sz = (item.app_len < lim) ? item.app_len : lim;
		seq_plus_one = item.seg_seq + 32'd1;
		seq_plus_len = item.seg_seq + {22'd0, plen};
		connected = (cur.link == tcsm_pkg::LS_EST) || (cur.link == tcsm_pkg::LS_FW1) ||
			(cur.link == tcsm_pkg::LS_FW2) || (cur.link == tcsm_pkg::LS_CLOSE_WAIT) ||
			(cur.link == tcsm_pkg::LS_LAST_ACK) || (cur.link == tcsm_pkg::LS_CLOSING);
	end

	always_comb begin
		nxt     = cur;
		snd     = 1'b0;
		fl      = 8'd0;
		sq      = 32'd0;
		ak      = 32'd0;
		pay     = 10'd0;
		deliver = 10'd0;
		fin_app = 1'b0;
		err     = 1'b0;
		unique case (tcsm_pkg::req_e_t'(item.req_type))
			tcsm_pkg::REQ_OPEN: begin
				if (cur.link == tcsm_pkg::LS_CLOSED) begin
					nxt.finished = 1'b0;
					if (cfg.active_open) begin
						snd      = 1'b1;
						fl       = tcsm_pkg::F_SYN;
						sq       = cfg.initial_seq;
						nxt.link = tcsm_pkg::LS_SYN_SENT;
					end else begin
						nxt.link = tcsm_pkg::LS_LISTEN;
					end
				end
			end
			tcsm_pkg::REQ_SEG: begin
				priority if (cur.link == tcsm_pkg::LS_CLOSED) begin
					nxt = cur;
				end else if (item.seg_truncated) begin
					err      = 1'b1;
					nxt.link = tcsm_pkg::LS_CLOSED;
				end else if (cur.link == tcsm_pkg::LS_SYN_SENT ||
						cur.link == tcsm_pkg::LS_SYN_RCVD) begin
					// both handshake ends land in established with fresh counters
					if (cur.link == tcsm_pkg::LS_SYN_SENT) begin
						snd = 1'b1;
						fl  = tcsm_pkg::F_ACK;
						sq  = item.seg_ack;
						ak  = seq_plus_one;
					end
					nxt.link          = tcsm_pkg::LS_EST;
					nxt.next_send_seq = tcsm_pkg::EST_SEQ;
					nxt.ack_to_send   = tcsm_pkg::EST_SEQ;
					nxt.peer_last_ack = tcsm_pkg::EST_SEQ;
					nxt.send_window   = tcsm_pkg::EST_WINDOW;
				end else if (cur.link == tcsm_pkg::LS_LISTEN) begin
					snd      = 1'b1;
					fl       = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK;
					sq       = cfg.initial_seq;
					ak       = seq_plus_one;
					nxt.link = tcsm_pkg::LS_SYN_RCVD;
				end else begin
					nxt.ack_to_send = seq_plus_len;
					if (item.seg_flags == (tcsm_pkg::F_FIN | tcsm_pkg::F_ACK)) begin
						if (cur.link == tcsm_pkg::LS_EST) begin
							nxt.link = tcsm_pkg::LS_CLOSE_WAIT;
						end else if (cur.link == tcsm_pkg::LS_FW2) begin
							nxt.link = tcsm_pkg::LS_CLOSED;
						end else if (cur.link == tcsm_pkg::LS_FW1) begin
							nxt.link = tcsm_pkg::LS_CLOSING;
						end
						fin_app         = 1'b1;
						snd             = 1'b1;
						fl              = tcsm_pkg::F_ACK;
						sq              = item.seg_ack;
						ak              = seq_plus_one;
						nxt.ack_to_send = seq_plus_one;
					end else begin
						if (plen != 10'd0) begin
							snd = 1'b1;
							fl  = tcsm_pkg::F_ACK;
							sq  = item.seg_ack;
							ak  = seq_plus_len;
						end else if (cur.link == tcsm_pkg::LS_FW1) begin
							nxt.link = tcsm_pkg::LS_FW2;
						end else if (cur.link == tcsm_pkg::LS_LAST_ACK ||
								cur.link == tcsm_pkg::LS_CLOSING) begin
							nxt.link = tcsm_pkg::LS_CLOSED;
						end
						nxt.send_window   = cur.send_window +
							(item.seg_ack - cur.peer_last_ack);
						nxt.peer_last_ack = item.seg_ack;
						deliver           = plen;
					end
					if (nxt.link == tcsm_pkg::LS_CLOSED) begin
						nxt.finished = 1'b1;
					end
				end
			end
			tcsm_pkg::REQ_APP: begin
				if (connected && cur.send_window != 32'd0) begin
					snd               = 1'b1;
					fl                = tcsm_pkg::F_ACK;
					sq                = cur.next_send_seq;
					ak                = cur.ack_to_send;
					pay               = sz;
					nxt.next_send_seq = cur.next_send_seq + {22'd0, sz};
					nxt.send_window   = cur.send_window - {22'd0, sz};
				end
			end
			tcsm_pkg::REQ_CLOSE: begin
				if (connected) begin
					if (cur.link == tcsm_pkg::LS_EST) begin
						nxt.link = tcsm_pkg::LS_FW1;
					end else if (cur.link == tcsm_pkg::LS_CLOSE_WAIT) begin
						nxt.link = tcsm_pkg::LS_LAST_ACK;
					end
					snd = 1'b1;
					fl  = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
					sq  = cur.next_send_seq;
					ak  = cur.ack_to_send;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res.send_valid       = snd;
		res.send_flags       = fl;
		res.send_seq         = sq;
		res.send_ack         = ak;
		res.send_win         = snd ? cfg.adv_window : 16'd0;
		res.send_payload_len = pay;
		res.deliver_len      = deliver;
		res.fin_to_app       = fin_app;
		res.conn_state       = tcsm_pkg::encode_state(nxt.link);
		res.done_res         = nxt.finished;
		res.error            = err;
	end

endmodule

// ===== rtl/tcp_connection_state_machine.sv =====
`timescale 1ns / 1ps
// top level of the tcp connection state machine: registers, handshakes, config
//
// One side of a simple tcp-like connection. Each input item is one event
// (open, received segment header, application data offered, close request);
// each item gives exactly one result item: an optional segment header plus the
// delivered length, fin indication, connection state, done and error flags.
// Input channel: in_valid/in_ready with the event fields as separate ports.
// Output channel: out_valid/out_ready with the result fields.
// An accepted item is registered in the input register, passes the step logic
// and is registered in the output register, which offers its result.
// Throughput: one item per cycle while out_ready is high; the connection
// registers are read and updated by one pass of compare-and-add logic between
// the input register and the output register. If out_ready is low, the output
// register holds its item, the input register fills, and in_ready drops until
// the output item is taken. Configuration (cfg_we, cfg_idx, cfg_wdata) is to
// be written by the user while no item is in flight; the block does not
// enforce this. Index 0 active open, 1 advertised window, 2 initial sequence.
// Reset (arst_n low) puts the link in closed with the default counters and
// registers and empties both item registers.
module tcp_connection_state_machine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	input  logic [7:0]  seg_flags,
	input  logic [9:0]  seg_payload_len,
	input  logic        seg_truncated,
	input  logic [9:0]  app_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_valid,
	output logic [7:0]  send_flags,
	output logic [31:0] send_seq,
	output logic [31:0] send_ack,
	output logic [15:0] send_win,
	output logic [9:0]  send_payload_len,
	output logic [9:0]  deliver_len,
	output logic        fin_to_app,
	output logic [3:0]  conn_state,
	output logic        done_res,
	output logic        error
);

	tcsm_pkg::cfg_t  cfg_q;
	tcsm_pkg::conn_t conn_q;
	tcsm_pkg::conn_t conn_nxt;
	tcsm_pkg::item_t item_s1;
	tcsm_pkg::res_t  res_nxt;
	tcsm_pkg::res_t  res_s2;
	logic            valid_s1;
	logic            valid_s2;
	logic            advance;
	logic            in_fire;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_open <= tcsm_pkg::RST_ACTIVE;
			cfg_q.adv_window  <= tcsm_pkg::RST_ADV_WIN;
			cfg_q.initial_seq <= tcsm_pkg::RST_INIT_SEQ;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tcsm_pkg::REG_ACTIVE_OPEN: cfg_q.active_open <= cfg_wdata[0];
				tcsm_pkg::REG_ADV_WINDOW:  cfg_q.adv_window  <= cfg_wdata[15:0];
				tcsm_pkg::REG_INITIAL_SEQ: cfg_q.initial_seq <= cfg_wdata;
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q.link          <= tcsm_pkg::LS_CLOSED;
			conn_q.next_send_seq <= tcsm_pkg::EST_SEQ;
			conn_q.ack_to_send   <= tcsm_pkg::EST_SEQ;
			conn_q.peer_last_ack <= tcsm_pkg::EST_SEQ;
			conn_q.send_window   <= tcsm_pkg::EST_WINDOW;
			conn_q.finished      <= 1'b0;
		end else if (advance) begin
			conn_q <= conn_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.req_type        <= req_type;
			item_s1.seg_seq         <= seg_seq;
			item_s1.seg_ack         <= seg_ack;
			item_s1.seg_flags       <= seg_flags;
			item_s1.seg_payload_len <= seg_payload_len;
			item_s1.seg_truncated   <= seg_truncated;
			item_s1.app_len         <= app_len;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	tcsm_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (conn_q),
		.nxt  (conn_nxt),
		.res  (res_nxt)
	);

	assign out_valid        = valid_s2;
	assign send_valid       = res_s2.send_valid;
	assign send_flags       = res_s2.send_flags;
	assign send_seq         = res_s2.send_seq;
	assign send_ack         = res_s2.send_ack;
	assign send_win         = res_s2.send_win;
	assign send_payload_len = res_s2.send_payload_len;
	assign deliver_len      = res_s2.deliver_len;
	assign fin_to_app       = res_s2.fin_to_app;
	assign conn_state       = res_s2.conn_state;
	assign done_res         = res_s2.done_res;
	assign error            = res_s2.error;

`ifndef SYNTH
	// an abort always leaves the link closed
	a_error_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.error) |-> (res_s2.conn_state == tcsm_pkg::CS_CLOSED))
		else $error("error item with link not closed");

	// done is only reported while the link sits in closed
	a_done_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> (res_s2.conn_state == tcsm_pkg::CS_CLOSED))
		else $error("done reported outside closed");

	// no header means an all-zero header
	a_no_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.send_valid) |->
		(res_s2.send_flags == 8'd0 && res_s2.send_win == 16'd0 &&
		 res_s2.send_payload_len == 10'd0))
		else $error("header fields set without send_valid");

	// a full pipe with a stalled receiver must hold off the sender
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while both item registers are held");

	// connection state only moves when an item passes to the output register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(conn_q))
		else $error("connection state changed without an item");
`endif

endmodule

// ===== tb/tb_tcp_connection_state_machine.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the tcp connection state machine
module tb_tcp_connection_state_machine;

	localparam int RUN_LIMIT   = 400000;
	localparam int N_RANDOM    = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;

	typedef enum logic {ROW_EVT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		tcsm_pkg::item_t it;
		bit              typed;
		tcsm_pkg::res_t  res;
		logic [1:0]      idx;
		logic [31:0]     wdata;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic [31:0] seg_seq = '0;
	logic [31:0] seg_ack = '0;
	logic [7:0]  seg_flags = '0;
	logic [9:0]  seg_payload_len = '0;
	logic        seg_truncated = 1'b0;
	logic [9:0]  app_len = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        send_valid;
	logic [7:0]  send_flags;
	logic [31:0] send_seq;
	logic [31:0] send_ack;
	logic [15:0] send_win;
	logic [9:0]  send_payload_len;
	logic [9:0]  deliver_len;
	logic        fin_to_app;
	logic [3:0]  conn_state;
	logic        done_res;
	logic        error;

	tcp_connection_state_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seg_seq(seg_seq),
		.seg_ack(seg_ack),
		.seg_flags(seg_flags),
		.seg_payload_len(seg_payload_len),
		.seg_truncated(seg_truncated),
		.app_len(app_len),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.send_valid(send_valid),
		.send_flags(send_flags),
		.send_seq(send_seq),
		.send_ack(send_ack),
		.send_win(send_win),
		.send_payload_len(send_payload_len),
		.deliver_len(deliver_len),
		.fin_to_app(fin_to_app),
		.conn_state(conn_state),
		.done_res(done_res),
		.error(error)
	);

	always #5 clk = ~clk;

	// model of the connection, kept in step with accepted items
	logic [3:0]  lnk = tcsm_pkg::CS_CLOSED;
	logic [31:0] nxt_seq = tcsm_pkg::EST_SEQ;
	logic [31:0] ack_out = tcsm_pkg::EST_SEQ;
	logic [31:0] peer_ack = tcsm_pkg::EST_SEQ;
	logic [31:0] snd_win = tcsm_pkg::EST_WINDOW;
	logic        fin_done = 1'b0;
	logic        c_active = tcsm_pkg::RST_ACTIVE;
	logic [15:0] c_adv = tcsm_pkg::RST_ADV_WIN;
	logic [31:0] c_init = tcsm_pkg::RST_INIT_SEQ;

	tcsm_pkg::res_t event_results[$];
	row_t           plan[$];
	int             fault_cnt = 0;
	int             cycle_cnt = 0;
	int             tx_idle_pct = 32;
	int             rx_idle_pct = 60;
	bit             hold_req = 1'b0;
	int             hold_cnt = 0;
	tcsm_pkg::res_t mon_got;
	tcsm_pkg::res_t mon_want;

	function automatic void enter_established();
		lnk      = tcsm_pkg::CS_EST;
		nxt_seq  = tcsm_pkg::EST_SEQ;
		ack_out  = tcsm_pkg::EST_SEQ;
		peer_ack = tcsm_pkg::EST_SEQ;
		snd_win  = tcsm_pkg::EST_WINDOW;
	endfunction

	function automatic tcsm_pkg::res_t advance_connection(tcsm_pkg::item_t it);
		tcsm_pkg::res_t r;
		logic [9:0]     plen;
		logic [9:0]     lim;
		logic [9:0]     sz;
		logic           conn;
		logic           snd;
		logic [7:0]     fl;
		logic [31:0]    sq;
		logic [31:0]    ak;
		logic [9:0]     pay;
		r    = '0;
		snd  = 1'b0;
		fl   = '0;
		sq   = '0;
		ak   = '0;
		pay  = '0;
		plen = (it.seg_payload_len > tcsm_pkg::MAX_SEGMENT) ? tcsm_pkg::MAX_SEGMENT :
			it.seg_payload_len;
		conn = (lnk == tcsm_pkg::CS_EST) || (lnk == tcsm_pkg::CS_FW1) ||
			(lnk == tcsm_pkg::CS_FW2) || (lnk == tcsm_pkg::CS_CLOSE_WAIT) ||
			(lnk == tcsm_pkg::CS_LAST_ACK) || (lnk == tcsm_pkg::CS_CLOSING);
		case (it.req_type)
			tcsm_pkg::REQ_OPEN: begin
				if (lnk == tcsm_pkg::CS_CLOSED) begin
					fin_done = 1'b0;
					if (c_active) begin
						snd = 1'b1;
						fl  = tcsm_pkg::F_SYN;
						sq  = c_init;
						lnk = tcsm_pkg::CS_SYN_SENT;
					end else begin
						lnk = tcsm_pkg::CS_LISTEN;
					end
				end
			end
			tcsm_pkg::REQ_SEG: begin
				if (lnk != tcsm_pkg::CS_CLOSED) begin
					if (it.seg_truncated) begin
						r.error = 1'b1;
						lnk = tcsm_pkg::CS_CLOSED;
					end else if (lnk == tcsm_pkg::CS_SYN_SENT) begin
						snd = 1'b1;
						fl  = tcsm_pkg::F_ACK;
						sq  = it.seg_ack;
						ak  = it.seg_seq + 32'd1;
						enter_established();
					end else if (lnk == tcsm_pkg::CS_LISTEN) begin
						snd = 1'b1;
						fl  = tcsm_pkg::F_SYN | tcsm_pkg::F_ACK;
						sq  = c_init;
						ak  = it.seg_seq + 32'd1;
						lnk = tcsm_pkg::CS_SYN_RCVD;
					end else if (lnk == tcsm_pkg::CS_SYN_RCVD) begin
						enter_established();
					end else begin
						ack_out = it.seg_seq + {22'd0, plen};
						if (it.seg_flags == (tcsm_pkg::F_FIN | tcsm_pkg::F_ACK)) begin
							if (lnk == tcsm_pkg::CS_EST)
								lnk = tcsm_pkg::CS_CLOSE_WAIT;
							else if (lnk == tcsm_pkg::CS_FW2)
								lnk = tcsm_pkg::CS_CLOSED;
							else if (lnk == tcsm_pkg::CS_FW1)
								lnk = tcsm_pkg::CS_CLOSING;
							r.fin_to_app = 1'b1;
							snd = 1'b1;
							fl  = tcsm_pkg::F_ACK;
							sq  = it.seg_ack;
							ak  = it.seg_seq + 32'd1;
							ack_out = it.seg_seq + 32'd1;
						end else begin
							if (plen != 10'd0) begin
								snd = 1'b1;
								fl  = tcsm_pkg::F_ACK;
								sq  = it.seg_ack;
								ak  = it.seg_seq + {22'd0, plen};
							end else begin
								// pure ack moves the closing states on
								if (lnk == tcsm_pkg::CS_FW1)
									lnk = tcsm_pkg::CS_FW2;
								else if (lnk == tcsm_pkg::CS_LAST_ACK ||
										lnk == tcsm_pkg::CS_CLOSING)
									lnk = tcsm_pkg::CS_CLOSED;
							end
							snd_win  = snd_win + (it.seg_ack - peer_ack);
							peer_ack = it.seg_ack;
							r.deliver_len = plen;
						end
						if (lnk == tcsm_pkg::CS_CLOSED)
							fin_done = 1'b1;
					end
				end
			end
			tcsm_pkg::REQ_APP: begin
				if (conn && snd_win != 32'd0) begin
					lim = (snd_win < {22'd0, tcsm_pkg::MAX_SEGMENT}) ? snd_win[9:0] :
						tcsm_pkg::MAX_SEGMENT;
					sz  = (it.app_len < lim) ? it.app_len : lim;
					snd = 1'b1;
					fl  = tcsm_pkg::F_ACK;
					sq  = nxt_seq;
					ak  = ack_out;
					pay = sz;
					nxt_seq = nxt_seq + {22'd0, sz};
					snd_win = snd_win - {22'd0, sz};
				end
			end
			default: begin
				if (conn) begin
					if (lnk == tcsm_pkg::CS_EST)
						lnk = tcsm_pkg::CS_FW1;
					else if (lnk == tcsm_pkg::CS_CLOSE_WAIT)
						lnk = tcsm_pkg::CS_LAST_ACK;
					snd = 1'b1;
					fl  = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
					sq  = nxt_seq;
					ak  = ack_out;
				end
			end
		endcase
		if (snd) begin
			r.send_valid       = 1'b1;
			r.send_flags       = fl;
			r.send_seq         = sq;
			r.send_ack         = ak;
			r.send_win         = c_adv;
			r.send_payload_len = pay;
		end
		r.conn_state = lnk;
		r.done_res   = fin_done;
		return r;
	endfunction

	function automatic row_t ev(logic [1:0] rq, logic [31:0] sq, logic [31:0] ak,
			logic [7:0] fl, logic [9:0] pl, logic tr, logic [9:0] al);
		row_t r;
		r.kind               = ROW_EVT;
		r.it.req_type        = rq;
		r.it.seg_seq         = sq;
		r.it.seg_ack         = ak;
		r.it.seg_flags       = fl;
		r.it.seg_payload_len = pl;
		r.it.seg_truncated   = tr;
		r.it.app_len         = al;
		r.typed              = 1'b0;
		r.res                = '0;
		r.idx                = '0;
		r.wdata              = '0;
		return r;
	endfunction

	// header-only results: no payload, nothing delivered, no fin
	function automatic row_t with_result(row_t r, logic [7:0] fl, logic [31:0] sq,
			logic [31:0] ak, logic [15:0] win, logic [3:0] st, logic dn, logic er);
		r.typed          = 1'b1;
		r.res            = '0;
		r.res.send_valid = (fl != 8'd0);
		r.res.send_flags = fl;
		r.res.send_seq   = sq;
		r.res.send_ack   = ak;
		r.res.send_win   = win;
		r.res.conn_state = st;
		r.res.done_res   = dn;
		r.res.error      = er;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] v);
		row_t r;
		r       = ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0);
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.wdata = v;
		return r;
	endfunction

	function automatic string fmt_res(tcsm_pkg::res_t r);
		return {$sformatf("v=%0d fl=%h seq=%h ack=%h win=%h pay=%0d ",
			r.send_valid, r.send_flags, r.send_seq, r.send_ack, r.send_win,
			r.send_payload_len),
			$sformatf("dlv=%0d fin=%0d st=%0d done=%0d err=%0d",
			r.deliver_len, r.fin_to_app, r.conn_state, r.done_res, r.error)};
	endfunction

	task automatic offer_event(input tcsm_pkg::item_t it, input bit use_typed,
			input tcsm_pkg::res_t typed_res);
		tcsm_pkg::res_t p;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		req_type        <= it.req_type;
		seg_seq         <= it.seg_seq;
		seg_ack         <= it.seg_ack;
		seg_flags       <= it.seg_flags;
		seg_payload_len <= it.seg_payload_len;
		seg_truncated   <= it.seg_truncated;
		app_len         <= it.app_len;
		do begin
			@(posedge clk);
		end while (!in_ready);
		p = advance_connection(it);
		event_results.push_back(use_typed ? typed_res : p);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (event_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			tcsm_pkg::REG_ACTIVE_OPEN: c_active = v[0];
			tcsm_pkg::REG_ADV_WINDOW:  c_adv = v[15:0];
			tcsm_pkg::REG_INITIAL_SEQ: c_init = v;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic retune_link();
		int p;
		wait_idle();
		write_reg(tcsm_pkg::REG_ACTIVE_OPEN, {31'd0, 1'($urandom_range(1))});
		p = $urandom_range(3);
		write_reg(tcsm_pkg::REG_ADV_WINDOW, (p == 0) ? 32'd0 : (p == 1) ? 32'h0000_ffff :
			{16'd0, 16'($urandom)});
		p = $urandom_range(3);
		write_reg(tcsm_pkg::REG_INITIAL_SEQ, (p == 0) ? 32'd0 : (p == 1) ? 32'hffff_ffff :
			$urandom);
	endtask

	// mostly well-formed sessions driven off the model's current state
	task automatic make_event(output tcsm_pkg::item_t it);
		int pick;
		int sub;
		it.req_type        = tcsm_pkg::REQ_SEG;
		it.seg_seq         = $urandom;
		it.seg_ack         = $urandom;
		it.seg_flags       = tcsm_pkg::F_ACK;
		it.seg_payload_len = 10'($urandom_range(1023));
		it.seg_truncated   = 1'b0;
		it.app_len         = 10'($urandom_range(1023));
		pick = $urandom_range(99);
		if (pick < 6) begin
			it.req_type      = 2'($urandom_range(3));
			it.seg_flags     = 8'($urandom_range(255));
			it.seg_truncated = 1'($urandom_range(1));
		end else if (lnk == tcsm_pkg::CS_CLOSED) begin
			it.req_type      = (pick < 85) ? tcsm_pkg::REQ_OPEN : 2'($urandom_range(3));
			it.seg_flags     = 8'($urandom_range(255));
			it.seg_truncated = 1'($urandom_range(1));
		end else if (lnk == tcsm_pkg::CS_SYN_SENT || lnk == tcsm_pkg::CS_LISTEN ||
				lnk == tcsm_pkg::CS_SYN_RCVD) begin
			it.req_type      = (pick < 80) ? tcsm_pkg::REQ_SEG : 2'($urandom_range(3));
			it.seg_flags     = 8'($urandom_range(255));
			it.seg_truncated = ($urandom_range(29) == 0);
		end else begin
			sub = $urandom_range(9);
			it.seg_payload_len = (sub < 3) ? 10'd0 : (sub == 9) ? 10'($urandom_range(1023)) :
				10'($urandom_range(tcsm_pkg::MAX_SEGMENT));
			sub = $urandom_range(9);
			it.app_len = (sub == 0) ? 10'd0 : (sub == 9) ? 10'($urandom_range(1023)) :
				10'($urandom_range(tcsm_pkg::MAX_SEGMENT));
			sub = $urandom_range(99);
			if (sub < 60)
				it.seg_ack = peer_ack + $urandom_range(600);
			else if (sub < 75)
				it.seg_ack = peer_ack - $urandom_range(600);
			else if (sub < 88)
				it.seg_ack = peer_ack - snd_win;  // closes the window
			if ($urandom_range(9) == 0)
				it.seg_flags = 8'($urandom_range(255));
			if (pick < 40) begin
				it.req_type = tcsm_pkg::REQ_APP;
			end else if (pick < 75) begin
				it.req_type = tcsm_pkg::REQ_SEG;
			end else if (pick < 83) begin
				it.req_type  = tcsm_pkg::REQ_SEG;
				it.seg_flags = tcsm_pkg::F_FIN | tcsm_pkg::F_ACK;
			end else if (pick < 95) begin
				it.req_type = tcsm_pkg::REQ_CLOSE;
			end else if (pick < 97) begin
				it.req_type      = tcsm_pkg::REQ_SEG;
				it.seg_truncated = 1'b1;
			end else begin
				it.req_type = tcsm_pkg::REQ_OPEN;
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mon_got.send_valid       = send_valid;
			mon_got.send_flags       = send_flags;
			mon_got.send_seq         = send_seq;
			mon_got.send_ack         = send_ack;
			mon_got.send_win         = send_win;
			mon_got.send_payload_len = send_payload_len;
			mon_got.deliver_len      = deliver_len;
			mon_got.fin_to_app       = fin_to_app;
			mon_got.conn_state       = conn_state;
			mon_got.done_res         = done_res;
			mon_got.error            = error;
			if (event_results.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("result with no item pending: %s", fmt_res(mon_got));
			end else begin
				mon_want = event_results.pop_front();
				if (mon_got.send_valid !== mon_want.send_valid ||
						mon_got.send_flags !== mon_want.send_flags ||
						mon_got.send_seq !== mon_want.send_seq ||
						mon_got.send_ack !== mon_want.send_ack ||
						mon_got.send_win !== mon_want.send_win ||
						mon_got.send_payload_len !== mon_want.send_payload_len ||
						mon_got.deliver_len !== mon_want.deliver_len ||
						mon_got.fin_to_app !== mon_want.fin_to_app ||
						mon_got.conn_state !== mon_want.conn_state ||
						mon_got.done_res !== mon_want.done_res ||
						mon_got.error !== mon_want.error) begin
					fault_cnt++;
					if (fault_cnt <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  exp %s", fmt_res(mon_want));
						$display("  got %s", fmt_res(mon_got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		tcsm_pkg::item_t it;
		// closed ignores everything but open
		plan.push_back(with_result(ev(tcsm_pkg::REQ_APP, '0, '0, '0, '0, 1'b0, 10'd536),
			'0, '0, '0, '0, tcsm_pkg::CS_CLOSED, 1'b0, 1'b0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_CLOSE, '0, '0, '0, '0, 1'b0, '0),
			'0, '0, '0, '0, tcsm_pkg::CS_CLOSED, 1'b0, 1'b0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_SEG, '1, '1, 8'hff, 10'h3ff, 1'b1, '0),
			'0, '0, '0, '0, tcsm_pkg::CS_CLOSED, 1'b0, 1'b0));
		// active open, extremes on the handshake ack
		plan.push_back(with_result(ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0),
			tcsm_pkg::F_SYN, 32'd1, '0, 16'd3072, tcsm_pkg::CS_SYN_SENT, 1'b0, 1'b0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0),
			'0, '0, '0, '0, tcsm_pkg::CS_SYN_SENT, 1'b0, 1'b0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_SEG, 32'hffff_ffff, 32'd5, '0, '0,
			1'b0, '0), tcsm_pkg::F_ACK, 32'd5, 32'd0, 16'd3072, tcsm_pkg::CS_EST,
			1'b0, 1'b0));
		// oversized payload, then zero window and reopened window
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd100, 32'd2, tcsm_pkg::F_ACK, 10'h3ff,
			1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd200, 32'hffff_f402, tcsm_pkg::F_ACK, '0,
			1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_APP, '0, '0, '0, '0, 1'b0, 10'd300));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd200, 32'd2, tcsm_pkg::F_ACK, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_APP, '0, '0, '0, '0, 1'b0, 10'h3ff));
		plan.push_back(ev(tcsm_pkg::REQ_APP, '0, '0, '0, '0, 1'b0, 10'd0));
		// passive close: peer fin, our fin, last ack
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'hffff_fff0, 32'd538,
			tcsm_pkg::F_FIN | tcsm_pkg::F_ACK, 10'd20, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_CLOSE, '0, '0, '0, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd7, 32'd539, tcsm_pkg::F_ACK, '0, 1'b0, '0));
		// reopen then abort on a truncated segment
		plan.push_back(ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_SEG, '0, '0, tcsm_pkg::F_ACK, '0,
			1'b1, '0), '0, '0, '0, '0, tcsm_pkg::CS_CLOSED, 1'b0, 1'b1));
		// passive open at the top extremes, simultaneous close
		plan.push_back(cfg_row(tcsm_pkg::REG_ACTIVE_OPEN, 32'd0));
		plan.push_back(cfg_row(tcsm_pkg::REG_ADV_WINDOW, 32'h0000_ffff));
		plan.push_back(cfg_row(tcsm_pkg::REG_INITIAL_SEQ, 32'hffff_ffff));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0),
			'0, '0, '0, '0, tcsm_pkg::CS_LISTEN, 1'b0, 1'b0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_SEG, 32'd0, 32'd0, tcsm_pkg::F_SYN, '0,
			1'b0, '0), tcsm_pkg::F_SYN | tcsm_pkg::F_ACK, 32'hffff_ffff, 32'd1, 16'hffff,
			tcsm_pkg::CS_SYN_RCVD, 1'b0, 1'b0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd1, 32'd2, tcsm_pkg::F_ACK, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_CLOSE, '0, '0, '0, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd50, 32'd2,
			tcsm_pkg::F_FIN | tcsm_pkg::F_ACK, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd51, 32'd3, '0, '0, 1'b0, '0));
		// bottom extremes, active close through fin_wait2
		plan.push_back(cfg_row(tcsm_pkg::REG_ACTIVE_OPEN, 32'd1));
		plan.push_back(cfg_row(tcsm_pkg::REG_ADV_WINDOW, 32'd0));
		plan.push_back(cfg_row(tcsm_pkg::REG_INITIAL_SEQ, 32'd0));
		plan.push_back(with_result(ev(tcsm_pkg::REQ_OPEN, '0, '0, '0, '0, 1'b0, '0),
			tcsm_pkg::F_SYN, 32'd0, 32'd0, 16'd0, tcsm_pkg::CS_SYN_SENT, 1'b0, 1'b0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd9, 32'd1,
			tcsm_pkg::F_SYN | tcsm_pkg::F_ACK, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_CLOSE, '0, '0, '0, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd10, 32'd3, tcsm_pkg::F_ACK, '0, 1'b0, '0));
		plan.push_back(ev(tcsm_pkg::REQ_SEG, 32'd10, 32'd3,
			tcsm_pkg::F_FIN | tcsm_pkg::F_ACK, '0, 1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				offer_event(plan[i].it, plan[i].typed, plan[i].res);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				tx_idle_pct = 60;
				rx_idle_pct = 32;
			end
			if (n == 2 * N_RANDOM / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// long receiver stall while items keep coming
			if (n == 2 * N_RANDOM / 3 + 50)
				hold_req = 1'b1;
			if (n == N_RANDOM / 6)
				wait_idle();
			if (lnk == tcsm_pkg::CS_CLOSED && $urandom_range(15) == 0)
				retune_link();
			make_event(it);
			offer_event(it, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (event_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
